// File: sv/hkm_pkg.sv
`timescale 1ns / 1ps

package hkm_pkg;

  // Slot table depth (1 to 32)
  localparam int Slots    = 6;
  localparam int SlotIdxW = (Slots > 1) ? $clog2(Slots) : 1;

  localparam int          ModBits      = 8;
  localparam int          ModIdxW      = $clog2(ModBits);
  localparam logic [7:0]  LibModBase   = 8'h80;
  localparam logic [7:0]  UsageModBase = 8'hE0;
  localparam logic [7:0]  UsageModTop  = 8'hE7;
  localparam logic [7:0]  KeyLow       = 8'h01;
  localparam logic [7:0]  KeyHigh      = 8'h77;
  localparam logic [7:0]  KeyOffset    = 8'd136;
  localparam logic [7:0]  CountMax     = 8'd255;

  typedef enum logic [1:0] {
    OP_PRESS       = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ACT_PRESS       = 2'd0,
    ACT_RELEASE     = 2'd1,
    ACT_RELEASE_ALL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic eval;
    logic emit;
  } hkm_cmd_t;

  typedef struct packed {
    logic pending;
    logic out_free;
  } hkm_sts_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } key_map_t;

  // Map a HID usage to its link-side code
  function automatic key_map_t hkm_map_usage(input logic [7:0] usage);
    key_map_t r;
    r.valid = 1'b0;
    r.code  = 8'd0;
    if (usage >= UsageModBase && usage <= UsageModTop) begin
      r.valid = 1'b1;
      r.code  = LibModBase + {5'd0, usage[2:0]};
    end else if (usage >= KeyLow && usage <= KeyHigh) begin
      r.valid = 1'b1;
      r.code  = usage + KeyOffset;
    end
    return r;
  endfunction

endpackage

// File: sv/hkm_ctrl.sv
`timescale 1ns / 1ps

module hkm_ctrl import hkm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hkm_sts_t sts_i,
  output hkm_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        // drop back to idle once nothing is left to send
        if (!sts_i.pending) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/hkm_dp.sv
`timescale 1ns / 1ps

module hkm_dp import hkm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hkm_cmd_t   cmd_i,
  output hkm_sts_t   sts_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] keycode_i,
  input  logic [7:0] modifier_i,
  input  logic       connected_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] action_o,
  output logic [7:0] lib_code_o,
  output logic       last_o
);

  // captured item
  logic [1:0] op_q;
  logic [7:0] key_q;
  logic [7:0] mods_q;
  logic       conn_q;

  logic       link_ready_q, link_ready_d;
  logic [7:0] cnt_q      [ModBits];
  logic [7:0] cnt_d      [ModBits];
  logic [7:0] slot_key_q [Slots];
  logic [7:0] slot_key_d [Slots];
  logic [7:0] slot_mod_q [Slots];
  logic [7:0] slot_mod_d [Slots];

  // words still owed for the current item
  logic [ModBits-1:0] mask_q, mask_d;
  logic               key_pend_q, key_pend_d;
  logic               all_pend_q, all_pend_d;
  logic [1:0]         act_q, act_d;
  logic [7:0]         code_q, code_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_action_q, out_action_d;
  logic [7:0] out_code_q, out_code_d;
  logic       out_last_q, out_last_d;

  logic                free_found, match_found;
  logic [SlotIdxW-1:0] free_idx, match_idx;
  key_map_t            key_map;
  logic [ModIdxW-1:0]  low_idx;
  logic [ModBits-1:0]  mask_rest;
  logic [7:0]          rel_mods;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      key_q  <= keycode_i;
      mods_q <= modifier_i;
      conn_q <= connected_i;
    end
    act_q        <= act_d;
    code_q       <= code_d;
    out_action_q <= out_action_d;
    out_code_q   <= out_code_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_ready_q <= 1'b0;
      mask_q       <= '0;
      key_pend_q   <= 1'b0;
      all_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int b = 0; b < ModBits; b++) begin
        cnt_q[b] <= '0;
      end
      for (int s = 0; s < Slots; s++) begin
        slot_key_q[s] <= '0;
        slot_mod_q[s] <= '0;
      end
    end else begin
      link_ready_q <= link_ready_d;
      mask_q       <= mask_d;
      key_pend_q   <= key_pend_d;
      all_pend_q   <= all_pend_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
      slot_key_q   <= slot_key_d;
      slot_mod_q   <= slot_mod_d;
    end
  end

  // first free slot and first slot holding the key, lowest index wins
  always_comb begin
    free_found  = 1'b0;
    match_found = 1'b0;
    free_idx    = '0;
    match_idx   = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (slot_key_q[s] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = SlotIdxW'(s);
      end
      if (slot_key_q[s] == key_q) begin
        match_found = 1'b1;
        match_idx   = SlotIdxW'(s);
      end
    end
  end

  // lowest pending modifier bit
  always_comb begin
    low_idx = '0;
    for (int b = ModBits - 1; b >= 0; b--) begin
      if (mask_q[b]) begin
        low_idx = ModIdxW'(b);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - ModBits'(1));
  assign key_map   = hkm_map_usage(key_q);
  assign rel_mods  = slot_mod_q[match_idx];

  always_comb begin
    link_ready_d = cfg_valid_i ? cfg_data_i : link_ready_q;
    mask_d       = mask_q;
    key_pend_d   = key_pend_q;
    all_pend_d   = all_pend_q;
    act_d        = act_q;
    code_d       = code_q;
    cnt_d        = cnt_q;
    slot_key_d   = slot_key_q;
    slot_mod_d   = slot_mod_q;
    out_action_d = out_action_q;
    out_code_d   = out_code_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;

    if (cmd_i.eval) begin
      mask_d     = '0;
      key_pend_d = 1'b0;
      all_pend_d = 1'b0;
      code_d     = key_map.code;
      case (op_q)
        OP_PRESS: begin
          act_d = ACT_PRESS;
          if (link_ready_q && conn_q) begin
            mask_d     = mods_q;
            key_pend_d = key_map.valid;
            for (int b = 0; b < ModBits; b++) begin
              if (mods_q[b] && cnt_q[b] != CountMax) begin
                cnt_d[b] = cnt_q[b] + 8'd1;
              end
            end
            if (mods_q != 8'd0 && key_q != 8'd0 && free_found) begin
              slot_key_d[free_idx] = key_q;
              slot_mod_d[free_idx] = mods_q;
            end
          end
        end
        OP_RELEASE: begin
          act_d = ACT_RELEASE;
          if (link_ready_q) begin
            key_pend_d = key_map.valid;
            if (key_q != 8'd0 && match_found) begin
              // a modifier goes up when its count ends at zero
              for (int b = 0; b < ModBits; b++) begin
                if (rel_mods[b]) begin
                  mask_d[b] = (cnt_q[b] <= 8'd1);
                  if (cnt_q[b] != 8'd0) begin
                    cnt_d[b] = cnt_q[b] - 8'd1;
                  end
                end
              end
              slot_key_d[match_idx] = '0;
              slot_mod_d[match_idx] = '0;
            end
          end
        end
        OP_RELEASE_ALL: begin
          act_d = ACT_RELEASE_ALL;
          if (link_ready_q) begin
            all_pend_d = 1'b1;
            for (int b = 0; b < ModBits; b++) begin
              cnt_d[b] = '0;
            end
            for (int s = 0; s < Slots; s++) begin
              slot_key_d[s] = '0;
              slot_mod_d[s] = '0;
            end
          end
        end
        default: begin
          act_d = ACT_PRESS;
        end
      endcase
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (mask_q != '0) begin
        out_action_d = act_q;
        out_code_d   = LibModBase + 8'(low_idx);
        out_last_d   = (mask_rest == '0) && !key_pend_q;
        mask_d       = mask_rest;
      end else if (key_pend_q) begin
        out_action_d = act_q;
        out_code_d   = code_q;
        out_last_d   = 1'b1;
        key_pend_d   = 1'b0;
      end else begin
        out_action_d = ACT_RELEASE_ALL;
        out_code_d   = 8'd0;
        out_last_d   = 1'b1;
        all_pend_d   = 1'b0;
      end
    end
  end

  assign sts_o.pending  = (mask_q != '0) || key_pend_q || all_pend_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign action_o    = out_action_q;
  assign lib_code_o  = out_code_q;
  assign last_o      = out_last_q;

endmodule

// File: sv/hid_key_modifier_refcount_tracker.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_ready_o    operation, keycode, modifier, connected
// out      output     out_valid_o / out_ready_i  action, lib_code, last
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_data_i = link_ready
//
// One item at a time: the block takes the word, then updates the
// modifier counts and slot table, then emits each word through the
// single output register, then sees that nothing is left; an item
// emits n = 0..9 words.
// An output stall holds the emit sequencer; a new item is taken while the
// final word of the previous one still waits in the output register.
// Reset clears the counts, the slot table, link_ready and all control state.

module hid_key_modifier_refcount_tracker import hkm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] keycode_i,
  input  logic [7:0] modifier_i,
  input  logic       connected_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] action_o,
  output logic [7:0] lib_code_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  hkm_cmd_t cmd;
  hkm_sts_t sts;

  // link_ready is a plain register write, always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: take, evaluate, then emit words until none remain
  hkm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // counts, slot table, pending-word bookkeeping and output register
  hkm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .keycode_i   (keycode_i),
    .modifier_i  (modifier_i),
    .connected_i (connected_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .action_o    (action_o),
    .lib_code_o  (lib_code_o),
    .last_o      (last_o)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import hkm_pkg::*;

  // Timing of the run
  localparam int LatPad     = 16;        // cycles to let an item with no words finish
  localparam int MaxReports = 10;
  localparam int PhaseItems = 16;
  localparam int StackItems = 6;         // untracked presses stacked on every count
  localparam longint TimeoutNs = 64'd5_000_000;

  // Operation code the block does not define; it must be dropped silently
  localparam logic [1:0] OpSpare = 2'd3;

  // One command word on the output channel
  typedef struct packed {
    action_e    act;
    logic [7:0] code;
    logic       last;
  } cmd_t;

  // Rows of the directed table: a link_ready write, an event checked
  // against the predictor, or an event whose outcome is typed in here
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       cfg_val;
    logic [1:0] op;
    logic [7:0] key;
    logic [7:0] mods;
    logic       conn;
    logic       n_words;   // typed rows: 0 or 1 words
    logic [1:0] act;
    logic [7:0] code;
  } dir_row_t;

  localparam int DirRows = 29;
  localparam dir_row_t DirTable [DirRows] = '{
    // link down: everything is dropped
    '{ROW_CFG,   1'b0, OP_PRESS,       8'h00, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_PRESS,       8'h04, 8'hFF, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_RELEASE_ALL, 8'h00, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_RELEASE,     8'h04, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    // link up
    '{ROW_CFG,   1'b1, OP_PRESS,       8'h00, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
    // press while the host is not connected is dropped
    '{ROW_TYPED, 1'b0, OP_PRESS,       8'h04, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_PRESS,       8'h04, 8'h00, 1'b1, 1'b1, ACT_PRESS,       8'h8C},
    // release does not care about connected
    '{ROW_TYPED, 1'b0, OP_RELEASE,     8'h04, 8'h00, 1'b0, 1'b1, ACT_RELEASE,     8'h8C},
    // all eight modifiers on the top key usage, then shared modifier bit 0
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h77, 8'hFF, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h01, 8'h01, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_RELEASE,     8'h77, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    // modifier usages at both ends of their range
    '{ROW_PRED,  1'b0, OP_PRESS,       8'hE0, 8'h80, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_PRESS,       8'hE7, 8'h00, 1'b1, 1'b1, ACT_PRESS,       8'h87},
    // keycode zero: modifiers counted, nothing tracked
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h00, 8'h02, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    // unmapped usages: no key word, modifiers still handled
    '{ROW_TYPED, 1'b0, OP_PRESS,       8'h78, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_PRESS,       8'hFF, 8'h10, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_RELEASE,     8'h00, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_RELEASE,     8'hFF, 8'h00, 1'b0, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_TYPED, 1'b0, OP_RELEASE,     8'hE8, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    // fill the slot table, then press one more tracked key
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h20, 8'h04, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h21, 8'h08, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h22, 8'h40, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h23, 8'h20, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_PRESS,       8'h24, 8'h01, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    '{ROW_PRED,  1'b0, OP_RELEASE,     8'h24, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    // undefined operation is dropped
    '{ROW_TYPED, 1'b0, OpSpare,        8'h04, 8'hFF, 1'b1, 1'b0, ACT_PRESS,       8'h00},
    // release everything, then keys that were held are plain releases
    '{ROW_TYPED, 1'b0, OP_RELEASE_ALL, 8'hAA, 8'h55, 1'b0, 1'b1, ACT_RELEASE_ALL, 8'h00},
    '{ROW_TYPED, 1'b0, OP_RELEASE,     8'h01, 8'h00, 1'b1, 1'b1, ACT_RELEASE,     8'h89},
    '{ROW_PRED,  1'b0, OP_RELEASE,     8'hE0, 8'h00, 1'b1, 1'b0, ACT_PRESS,       8'h00}
  };

  // Idling per random phase: sender gap and receiver stall, percent
  localparam int PhaseGap   [4] = '{0, 45, 0, 16};
  localparam int PhaseStall [4] = '{0, 0, 45, 16};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] operation = OP_PRESS;
  logic [7:0] keycode = 8'h00;
  logic [7:0] modifier = 8'h00;
  logic       connected = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] action;
  logic [7:0] lib_code;
  logic       last_flag;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       link_data = 1'b0;

  int gap_pct = 0;
  int stall_pct = 0;
  int fail_cnt = 0;

  // Predictor state: modifier reference counts, slot table, link register
  logic [7:0] mod_refs [ModBits];
  logic [7:0] slot_key [Slots];
  logic [7:0] slot_mods [Slots];
  logic       link_up;

  cmd_t pred_burst [9];     // words of the item just accepted
  cmd_t pending_cmds [$];   // words still owed by the block, oldest first

  hid_key_modifier_refcount_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .keycode_i   (keycode),
    .modifier_i  (modifier),
    .connected_i (connected),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .action_o    (action),
    .lib_code_o  (lib_code),
    .last_o      (last_flag),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (link_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Link-side code of a usage; returns 0 when the usage has none
  function automatic logic link_code(input logic [7:0] usage, output logic [7:0] code);
    code = 8'h00;
    if (usage >= UsageModBase && usage <= UsageModTop) begin
      code = usage - UsageModBase + LibModBase;
      return 1'b1;
    end
    if (usage >= KeyLow && usage <= KeyHigh) begin
      code = usage + KeyOffset;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predictor by one accepted event; fill pred_burst and
  // return how many command words the block owes for it
  function automatic int predict_commands(input logic [1:0] op, input logic [7:0] key,
                                          input logic [7:0] mods, input logic conn);
    int         n;
    logic [7:0] code;
    logic       hit;
    n = 0;
    if (!link_up) return 0;
    case (op)
      OP_PRESS: begin
        if (conn) begin
          for (int b = 0; b < ModBits; b++) begin
            if (mods[b]) begin
              pred_burst[n] = '{ACT_PRESS, LibModBase + 8'(b), 1'b0};
              n++;
              if (mod_refs[b] != CountMax) mod_refs[b]++;
            end
          end
          // track the key with its mask in the first free slot, if any
          if (mods != 8'h00 && key != 8'h00) begin
            hit = 1'b0;
            for (int s = 0; s < Slots; s++) begin
              if (!hit && slot_key[s] == 8'h00) begin
                slot_key[s]  = key;
                slot_mods[s] = mods;
                hit = 1'b1;
              end
            end
          end
          if (link_code(key, code)) begin
            pred_burst[n] = '{ACT_PRESS, code, 1'b0};
            n++;
          end
        end
      end
      OP_RELEASE: begin
        if (key != 8'h00) begin
          hit = 1'b0;
          for (int s = 0; s < Slots; s++) begin
            if (!hit && slot_key[s] == key) begin
              hit = 1'b1;
              // drop one reference per modifier; release it once unused
              for (int b = 0; b < ModBits; b++) begin
                if (slot_mods[s][b]) begin
                  if (mod_refs[b] != 8'h00) mod_refs[b]--;
                  if (mod_refs[b] == 8'h00) begin
                    pred_burst[n] = '{ACT_RELEASE, LibModBase + 8'(b), 1'b0};
                    n++;
                  end
                end
              end
              slot_key[s]  = 8'h00;
              slot_mods[s] = 8'h00;
            end
          end
        end
        if (link_code(key, code)) begin
          pred_burst[n] = '{ACT_RELEASE, code, 1'b0};
          n++;
        end
      end
      OP_RELEASE_ALL: begin
        for (int s = 0; s < Slots; s++) begin
          slot_key[s]  = 8'h00;
          slot_mods[s] = 8'h00;
        end
        for (int b = 0; b < ModBits; b++) mod_refs[b] = 8'h00;
        pred_burst[n] = '{ACT_RELEASE_ALL, 8'h00, 1'b0};
        n++;
      end
      default: ;
    endcase
    if (n > 0) pred_burst[n-1].last = 1'b1;
    return n;
  endfunction

  // Drive one event word; on acceptance queue the words it should cause,
  // either from the predictor or from the typed-in expectation
  task automatic send_event(input logic [1:0] op, input logic [7:0] key, input logic [7:0] mods,
                            input logic conn, input logic typed, input logic typed_n,
                            input cmd_t typed_cmd);
    int n;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    keycode   <= key;
    modifier  <= mods;
    connected <= conn;
    do @(posedge clk); while (!in_ready);
    n = predict_commands(op, key, mods, conn);
    if (typed) begin
      if (typed_n) pending_cmds.push_back(typed_cmd);
    end else begin
      for (int i = 0; i < n; i++) pending_cmds.push_back(pred_burst[i]);
    end
  endtask

  // Hold the sender off until every owed word has come out, then let
  // the block finish any item that owes none
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LatPad) @(posedge clk);
  endtask

  task automatic write_link(input logic val);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    link_data <= val;
    do @(posedge clk); while (!cfg_ready);
    link_up = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: presses of real keys with modifiers and
  // releases of keys that are held; the rest is noise
  task automatic send_random_event(output logic counted);
    logic [1:0] op;
    logic [7:0] key;
    logic [7:0] mods;
    logic       conn;
    logic [7:0] held [$];
    int         r;
    r    = $urandom_range(99);
    op   = (r < 52) ? OP_PRESS : (r < 92) ? OP_RELEASE : (r < 96) ? OP_RELEASE_ALL : OpSpare;
    conn = ($urandom_range(99) < 92);
    r    = $urandom_range(99);
    key  = (r < 60) ? 8'($urandom_range(KeyHigh, KeyLow)) :
           (r < 75) ? 8'($urandom_range(UsageModTop, UsageModBase)) :
           (r < 85) ? 8'h00 : 8'($urandom_range(255));
    r    = $urandom_range(99);
    mods = (r < 30) ? 8'h00 : (r < 60) ? 8'(1 << $urandom_range(7)) : 8'($urandom_range(255));
    if (op == OP_RELEASE) begin
      foreach (slot_key[s]) if (slot_key[s] != 8'h00) held.push_back(slot_key[s]);
      if (held.size() != 0 && $urandom_range(99) < 65)
        key = held[$urandom_range(held.size() - 1)];
    end
    counted = link_up && op != OpSpare && !(op == OP_PRESS && !conn);
    send_event(op, key, mods, conn, 1'b0, 1'b0, '0);
  endtask

  // Receiver: stall at random, at the rate of the current phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted word against the oldest one owed
  always @(posedge clk) begin : check_words
    cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("unexpected word: action %0d code %02h last %0b",
                   action, lib_code, last_flag);
      end else begin
        want = pending_cmds.pop_front();
        if (action !== want.act || lib_code !== want.code || last_flag !== want.last) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("word mismatch: expected action %0d code %02h last %0b, got %0d %02h %0b",
                     want.act, want.code, want.last, action, lib_code, last_flag);
        end
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic counted;
    int   done;

    link_up = 1'b0;
    foreach (mod_refs[b]) mod_refs[b] = 8'h00;
    foreach (slot_key[s]) begin
      slot_key[s]  = 8'h00;
      slot_mods[s] = 8'h00;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table with no idling
    for (int r = 0; r < DirRows; r++) begin
      if (DirTable[r].kind == ROW_CFG) begin
        write_link(DirTable[r].cfg_val);
      end else begin
        send_event(DirTable[r].op, DirTable[r].key, DirTable[r].mods, DirTable[r].conn,
                   DirTable[r].kind == ROW_TYPED, DirTable[r].n_words,
                   '{action_e'(DirTable[r].act), DirTable[r].code, 1'b1});
      end
    end

    // Stack untracked presses on every count, then hold and release a
    // tracked key: a count still held by other presses must not release
    gap_pct   = 16;
    stall_pct = 16;
    repeat (StackItems) send_event(OP_PRESS, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0, '0);
    send_event(OP_PRESS, 8'h30, 8'h81, 1'b1, 1'b0, 1'b0, '0);
    send_event(OP_RELEASE, 8'h30, 8'h00, 1'b1, 1'b0, 1'b0, '0);
    send_event(OP_RELEASE_ALL, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, '0);

    // Random phases, one per idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      write_link(1'b1);
      gap_pct   = PhaseGap[ph];
      stall_pct = PhaseStall[ph];
      done = 0;
      while (done < PhaseItems) begin
        // pause the sender now and then until the block has caught up
        if (done == 10 || $urandom_range(99) < 3) drain_results();
        send_random_event(counted);
        if (counted) done++;
      end
    end

    // Link down again: every event is dropped; then bring it back up
    write_link(1'b0);
    repeat (8) send_random_event(counted);
    write_link(1'b1);
    repeat (10) send_random_event(counted);

    drain_results();
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
